// ===== src/sflf_pkg.sv =====
package sflf_pkg;

  localparam int VAL_W         = 48;
  localparam int MAG_W         = 47;
  localparam int WIDE_W        = 63;
  localparam int FRAC_BITS_DEF = 32;
  localparam int PROD_W        = 2 * VAL_W;
  localparam int SUM_W         = 2 * VAL_W;
  localparam int NORM_W        = VAL_W;
  localparam int CROSS_W       = PROD_W + 1;
  localparam int RR_W          = 2 * MAG_W;
  localparam int AP_W          = MAG_W + WIDE_W;
  localparam int FP_W          = 2 * WIDE_W;
  localparam int KX_W          = WIDE_W + 10;
  localparam int K_DEN         = 100;
  localparam int K_DEN_W       = 7;
  localparam int IN_DATA_W     = 432;
  localparam int OUT_DATA_W    = 144;

  localparam logic [WIDE_W-1:0] WIDE_LIM = '1;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [WIDE_W-1:0] wide_t;

endpackage

// ===== src/sflf_mul.sv =====
module sflf_mul #(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic [AW+BW-1:0] p
);

  logic [63:0]  a64;
  logic [63:0]  b64;
  logic [63:0]  p00;
  logic [63:0]  p01;
  logic [63:0]  p10;
  logic [63:0]  p11;
  logic [127:0] sum;

  assign a64 = 64'(a);
  assign b64 = 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a64[31:0] * b64[31:0];
      p01 <= a64[31:0] * b64[63:32];
      p10 <= a64[63:32] * b64[31:0];
      p11 <= a64[63:32] * b64[63:32];
    end
  end

  assign sum = {p11, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[AW+BW-1:0];
    end
  end

endmodule

// ===== src/sflf_sqrt.sv =====
module sflf_sqrt #(
  parameter int  IW = 96,
  localparam int OW = (IW + 1) / 2
) (
  input  logic          clk,
  input  logic          en,
  input  logic [IW-1:0] din,
  output logic [OW-1:0] root
);

  localparam int XW  = 2 * OW;
  localparam int RMW = OW + 2;

  logic [XW-1:0]  xs [0:OW-1];
  logic [OW-1:0]  rt [0:OW];
  logic [RMW-1:0] rm [0:OW-1];

  assign xs[0] = XW'(din);
  assign rt[0] = '0;
  assign rm[0] = '0;

  for (genvar k = 1; k <= OW; k++) begin : g_stage
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    logic           ge;

    assign cur   = {rm[k-1][OW-1:0], xs[k-1][XW-1 -: 2]};
    assign trial = {rt[k-1], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k] <= {rt[k-1][OW-2:0], ge};
      end
    end

    if (k < OW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          xs[k] <= {xs[k-1][XW-3:0], 2'b00};
          rm[k] <= ge ? cur - trial : cur;
        end
      end
    end
  end

  assign root = rt[OW];

endmodule

// ===== src/sflf_div.sv =====
module sflf_div #(
  parameter int NW = 111,
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] ns [0:NW];
  logic [DW-1:0] rm [0:NW-1];
  logic [DW-1:0] ds [0:NW-1];

  assign ns[0] = num;
  assign rm[0] = '0;
  assign ds[0] = den;

  for (genvar k = 1; k <= NW; k++) begin : g_stage
    logic [DW:0] cur;
    logic [DW:0] diff;
    logic        ge;

    assign cur  = {rm[k-1], ns[k-1][NW-1]};
    assign ge   = cur >= {1'b0, ds[k-1]};
    assign diff = cur - {1'b0, ds[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        ns[k] <= {ns[k-1][NW-2:0], ge};
      end
    end

    if (k < NW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rm[k] <= ge ? diff[DW-1:0] : cur[DW-1:0];
          ds[k] <= ds[k-1];
        end
      end
    end
  end

  assign quo = ns[NW];

endmodule

// ===== src/sflf_dly.sv =====
module sflf_dly #(
  parameter int W = 1,
  parameter int L = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [L];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int k = 1; k < L; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign dout = sr[L-1];

endmodule

// ===== src/saffman_lift_force_unit.sv =====
// Saffman lift force, one particle per request.
// Input stream (s_*): one request carries the negated slip velocity, the fluid
// vorticity, density, kinematic viscosity and particle radius, all fixed point
// with FRAC_BITS fraction bits. Output stream (m_*): the lift force vector in
// m_tdata and the saturation flag in m_tuser.
// The block forms (slip x vorticity), |w| by a digit-recurrence root, the
// quotient nu / |w| by a one-bit-per-stage divider, its root, the coefficient
// 6.46 * rho * r^2 * sqrt(nu/|w|) and the scaled force. Zero vorticity gives a
// zero force with the flag clear.
// Throughput: one request per cycle while the receiver accepts results. The
// vorticity root, the divider (QW = 47 + 2*FRAC_BITS bits) and the second
// root, one stage per result bit, make up most of the pipeline depth.
// Reset clears every valid bit; requests in flight are dropped.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated.
module saffman_lift_force_unit
  import sflf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // slip_x, slip_y, slip_z, vort_x, vort_y, vort_z, density, viscosity, radius
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // lift_x, lift_y, lift_z
  output logic [OUT_DATA_W-1:0] m_tdata,
  // saturated
  output logic [0:0]            m_tuser
);

  localparam int QW     = MAG_W + 2 * FRAC_BITS;
  localparam int RW     = (QW + 1) / 2;
  localparam int BP_W   = WIDE_W + RW;
  localparam int KD_N   = (KX_W + 7) / 8;
  localparam int KD_W   = 8 * KD_N;
  localparam int KD_M   = 41944;
  localparam int T_NORM = 4 + NORM_W;
  localparam int T_Q    = T_NORM + QW;
  localparam int T_R    = T_Q + RW;
  localparam int T_B    = T_R + 3;
  localparam int T_X    = T_R + 4;
  localparam int T_K    = T_X + KD_N + 1;
  localparam int T_OUT  = T_K + 3;

  logic              en;
  logic [T_OUT:1]    vld;

  val_t              sv [3];
  val_t              wv [3];
  val_t              sm1 [3];
  val_t              wm1 [3];
  logic              sn1 [3];
  logic              wn1 [3];
  logic [MAG_W-1:0]  rho1;
  logic [MAG_W-1:0]  nu1;
  logic [MAG_W-1:0]  rad1;
  logic              zero1;

  logic [PROD_W-1:0] wsq [3];
  logic [RR_W-1:0]   rr;
  logic [RR_W-1:0]   rr_sh;
  logic [SUM_W-1:0]  sum4;
  wide_t             r2_4;
  logic              r2f4;

  wide_t             cm5 [3];
  logic              cn5 [3];
  logic [2:0]        cmclip;
  logic              f5;
  logic              f6;

  logic [MAG_W-1:0]  rho4;
  logic [AP_W-1:0]   ap;
  logic [AP_W-1:0]   ash;
  wide_t             a7;
  logic              f7;

  logic [NORM_W-1:0] norm;
  logic [MAG_W-1:0]  nu_n;
  logic [QW-1:0]     num;
  logic [QW-1:0]     quo;
  logic [RW-1:0]     root;

  wide_t             a_r;
  logic              f7_r;
  logic [BP_W-1:0]   bp;
  logic [BP_W-1:0]   bsh;
  wide_t             b;
  logic              fb;
  logic [KX_W-1:0]   x;
  logic [KX_W-1:0]   kq;
  logic              fb_k;
  wide_t             k;
  logic              fk;
  logic              fk_o;

  logic [KD_W-1:0]    kd_n [0:KD_N-1];
  logic [K_DEN_W-1:0] kd_r [0:KD_N-1];
  logic [KD_W-1:0]    kd_q [0:KD_N];

  logic [3*WIDE_W-1:0] cm_k;
  logic [2:0]          cn_o;
  logic                zero_o;
  logic [2:0]          ovf;
  val_t                lift_next [3];
  val_t                lift [3];
  logic                sat;

  assign en       = !vld[T_OUT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[T_OUT];
  assign m_tdata  = {lift[2], lift[1], lift[0]};
  assign m_tuser  = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_OUT-1:1], s_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i] = s_tdata[i*VAL_W +: VAL_W];
      wv[i] = s_tdata[(3+i)*VAL_W +: VAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sn1[i] <= sv[i][VAL_W-1];
        wn1[i] <= wv[i][VAL_W-1];
        sm1[i] <= sv[i][VAL_W-1] ? -sv[i] : sv[i];
        wm1[i] <= wv[i][VAL_W-1] ? -wv[i] : wv[i];
      end
      rho1  <= s_tdata[6*VAL_W +: MAG_W];
      nu1   <= s_tdata[6*VAL_W+MAG_W +: MAG_W];
      rad1  <= s_tdata[6*VAL_W+2*MAG_W +: MAG_W];
      zero1 <= (wv[0] == '0) && (wv[1] == '0) && (wv[2] == '0);
    end
  end

  sflf_mul #(.AW(MAG_W), .BW(MAG_W)) u_mul_rr (
    .clk(clk), .en(en), .a(rad1), .b(rad1), .p(rr)
  );

  assign rr_sh = rr >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      sum4 <= wsq[0] + wsq[1] + wsq[2];
      r2f4 <= |rr_sh[RR_W-1:WIDE_W];
      r2_4 <= (|rr_sh[RR_W-1:WIDE_W]) ? WIDE_LIM : rr_sh[WIDE_W-1:0];
      f5   <= r2f4 || (|cmclip);
      f6   <= f5;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J1 = (i + 1) % 3;
    localparam int J2 = (i + 2) % 3;

    logic [PROD_W-1:0]  pa;
    logic [PROD_W-1:0]  pb;
    logic               na2;
    logic               nb2;
    logic               na3;
    logic               nb3;
    logic [CROSS_W-1:0] ea;
    logic [CROSS_W-1:0] eb;
    logic [CROSS_W-1:0] c4;
    logic [CROSS_W-1:0] cmag;
    logic [CROSS_W-1:0] csh;
    logic [FP_W-1:0]    fp;
    logic [FP_W-1:0]    fsh;
    logic               ovf_l;

    sflf_mul #(.AW(VAL_W), .BW(VAL_W)) u_mul_sq (
      .clk(clk), .en(en), .a(wm1[i]), .b(wm1[i]), .p(wsq[i])
    );
    sflf_mul #(.AW(VAL_W), .BW(VAL_W)) u_mul_pa (
      .clk(clk), .en(en), .a(sm1[J1]), .b(wm1[J2]), .p(pa)
    );
    sflf_mul #(.AW(VAL_W), .BW(VAL_W)) u_mul_pb (
      .clk(clk), .en(en), .a(sm1[J2]), .b(wm1[J1]), .p(pb)
    );

    assign ea        = na3 ? -{1'b0, pa} : {1'b0, pa};
    assign eb        = nb3 ? -{1'b0, pb} : {1'b0, pb};
    assign cmag      = c4[CROSS_W-1] ? -c4 : c4;
    assign csh       = cmag >> FRAC_BITS;
    assign cmclip[i] = |csh[CROSS_W-1:WIDE_W];

    always_ff @(posedge clk) begin
      if (en) begin
        na2    <= sn1[J1] ^ wn1[J2];
        nb2    <= sn1[J2] ^ wn1[J1];
        na3    <= na2;
        nb3    <= nb2;
        c4     <= ea - eb;
        cn5[i] <= c4[CROSS_W-1];
        cm5[i] <= cmclip[i] ? WIDE_LIM : csh[WIDE_W-1:0];
      end
    end

    sflf_mul #(.AW(WIDE_W), .BW(WIDE_W)) u_mul_f (
      .clk(clk), .en(en), .a(cm_k[i*WIDE_W +: WIDE_W]), .b(k), .p(fp)
    );

    assign fsh    = fp >> FRAC_BITS;
    assign ovf[i] = ovf_l;

    always_comb begin
      if (cn_o[i]) begin
        ovf_l        = (|fsh[FP_W-1:VAL_W]) || (fsh[VAL_W-1] && (|fsh[VAL_W-2:0]));
        lift_next[i] = ovf_l ? {1'b1, {(VAL_W-1){1'b0}}} : -fsh[VAL_W-1:0];
      end else begin
        ovf_l        = |fsh[FP_W-1:VAL_W-1];
        lift_next[i] = ovf_l ? {1'b0, {(VAL_W-1){1'b1}}} : {1'b0, fsh[VAL_W-2:0]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lift[i] <= zero_o ? '0 : lift_next[i];
      end
    end
  end

  sflf_dly #(.W(MAG_W), .L(3)) u_dly_rho (
    .clk(clk), .en(en), .din(rho1), .dout(rho4)
  );

  sflf_mul #(.AW(MAG_W), .BW(WIDE_W)) u_mul_a (
    .clk(clk), .en(en), .a(rho4), .b(r2_4), .p(ap)
  );

  assign ash = ap >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      a7 <= (|ash[AP_W-1:WIDE_W]) ? WIDE_LIM : ash[WIDE_W-1:0];
      f7 <= f6 || (|ash[AP_W-1:WIDE_W]);
    end
  end

  sflf_sqrt #(.IW(SUM_W)) u_sqrt_norm (
    .clk(clk), .en(en), .din(sum4), .root(norm)
  );

  sflf_dly #(.W(MAG_W), .L(T_NORM - 1)) u_dly_nu (
    .clk(clk), .en(en), .din(nu1), .dout(nu_n)
  );

  assign num = {nu_n, {(2*FRAC_BITS){1'b0}}};

  sflf_div #(.NW(QW), .DW(NORM_W)) u_div_nu (
    .clk(clk), .en(en), .num(num), .den(norm), .quo(quo)
  );

  sflf_sqrt #(.IW(QW)) u_sqrt_q (
    .clk(clk), .en(en), .din(quo), .root(root)
  );

  sflf_dly #(.W(WIDE_W), .L(T_R - 7)) u_dly_a (
    .clk(clk), .en(en), .din(a7), .dout(a_r)
  );

  sflf_dly #(.W(1), .L(T_R - 5)) u_dly_f7 (
    .clk(clk), .en(en), .din(f7), .dout(f7_r)
  );

  sflf_mul #(.AW(WIDE_W), .BW(RW)) u_mul_b (
    .clk(clk), .en(en), .a(a_r), .b(root), .p(bp)
  );

  assign bsh = bp >> FRAC_BITS;

  // 6.46 * b = (b * 646) / 100
  always_ff @(posedge clk) begin
    if (en) begin
      b  <= (|bsh[BP_W-1:WIDE_W]) ? WIDE_LIM : bsh[WIDE_W-1:0];
      fb <= f7_r || (|bsh[BP_W-1:WIDE_W]);
      x  <= KX_W'({b, 9'd0}) + KX_W'({b, 7'd0}) + KX_W'({b, 2'd0}) + KX_W'({b, 1'b0});
    end
  end

  // divide by 100 one byte per stage, digit by reciprocal multiply
  assign kd_n[0] = KD_W'(x);
  assign kd_r[0] = '0;
  assign kd_q[0] = '0;

  for (genvar j = 1; j <= KD_N; j++) begin : g_kdiv
    logic [14:0] kv;
    logic [30:0] kp;
    logic [7:0]  kd;
    logic [14:0] kr;

    assign kv = {kd_r[j-1], kd_n[j-1][KD_W-1 -: 8]};
    assign kp = 31'(kv) * 31'(KD_M);
    assign kd = kp[29:22];
    assign kr = kv - 15'(kd) * 15'(K_DEN);

    always_ff @(posedge clk) begin
      if (en) begin
        kd_q[j] <= {kd_q[j-1][KD_W-9:0], kd};
      end
    end

    if (j < KD_N) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          kd_n[j] <= {kd_n[j-1][KD_W-9:0], 8'd0};
          kd_r[j] <= kr[K_DEN_W-1:0];
        end
      end
    end
  end

  assign kq = kd_q[KD_N][KX_W-1:0];

  sflf_dly #(.W(1), .L(T_K - 1 - T_B)) u_dly_fb (
    .clk(clk), .en(en), .din(fb), .dout(fb_k)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      k  <= (|kq[KX_W-1:WIDE_W]) ? WIDE_LIM : kq[WIDE_W-1:0];
      fk <= fb_k || (|kq[KX_W-1:WIDE_W]);
    end
  end

  sflf_dly #(.W(3 * WIDE_W), .L(T_K - 5)) u_dly_cm (
    .clk(clk), .en(en), .din({cm5[2], cm5[1], cm5[0]}), .dout(cm_k)
  );

  sflf_dly #(.W(3), .L(T_K - 3)) u_dly_cn (
    .clk(clk), .en(en), .din({cn5[2], cn5[1], cn5[0]}), .dout(cn_o)
  );

  sflf_dly #(.W(1), .L(2)) u_dly_fk (
    .clk(clk), .en(en), .din(fk), .dout(fk_o)
  );

  sflf_dly #(.W(1), .L(T_OUT - 2)) u_dly_zero (
    .clk(clk), .en(en), .din(zero1), .dout(zero_o)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sat <= !zero_o && (fk_o || (|ovf));
    end
  end

  a_zero_quiet: assert property (@(posedge clk) disable iff (rst)
    en && vld[T_OUT-1] && zero_o |=> m_tdata == '0 && m_tuser == '0)
    else $error("zero vorticity request produced a nonzero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> vld == '0)
    else $error("valid bits not cleared by reset");

endmodule
